// ----- rtl/pcrc_pkg.sv -----
// Package for the packet CRC-16 checker: sizes, verdict codes, the result
// record and the byte-wide CRC-16 update. No dependencies.
`default_nettype none

package pcrc_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LENGTH_W         = 12;
    localparam int TOTAL_W          = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_MISMATCH  = 2'd1;
    localparam logic [1:0] VERDICT_TOO_SHORT = 2'd2;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [1:0]          verdict;
        logic [15:0]         calc_crc;
        logic [15:0]         trailer_crc;
        logic [LENGTH_W-1:0] payload_length;
        logic [TOTAL_W-1:0]  packets_total;
        logic [TOTAL_W-1:0]  error_total;
        logic [TOTAL_W-1:0]  ok_total;
    } t_result;

    // One byte through CRC-16/CCITT, MSB first, no reflection.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcrc_if.sv -----
// Handshake interfaces for the packet CRC-16 checker: byte requests in and
// packet results out. Depends on pcrc_pkg.
`default_nettype none

interface pcrc_byte_if;
    import pcrc_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface pcrc_result_if;
    import pcrc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          verdict;
    logic [15:0]         calc_crc;
    logic [15:0]         trailer_crc;
    logic [LENGTH_W-1:0] payload_length;
    logic [TOTAL_W-1:0]  packets_total;
    logic [TOTAL_W-1:0]  error_total;
    logic [TOTAL_W-1:0]  ok_total;

    modport source (output valid, verdict, calc_crc, trailer_crc, payload_length,
                    packets_total, error_total, ok_total, input ready);
    modport sink   (input valid, verdict, calc_crc, trailer_crc, payload_length,
                    packets_total, error_total, ok_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/pcrc_engine.sv -----
// Per-packet state of the checker: running CRC, two-byte trailer delay,
// byte count and the three wrapping counters. Depends on pcrc_pkg.
`default_nettype none

module pcrc_engine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_data,
    input  wire logic             i_last,
    output pcrc_pkg::t_result     o_result
);
    import pcrc_pkg::*;

    logic [15:0]        r_crc, n_crc;
    logic [15:0]        r_delay;
    t_count             r_count, n_count;
    logic [TOTAL_W-1:0] r_packets, r_errors, r_oks;
    logic [15:0]        recv;
    logic               too_short;
    logic               match;
    logic [COUNT_W-1:0] plen_full;

    // The oldest held byte is payload once two bytes sit in the delay line.
    always_comb begin
        n_crc     = (r_count >= t_count'(2)) ? crc16_byte(r_crc, r_delay[15:8]) : r_crc;
        n_count   = (r_count < t_count'(MAX_PACKET_BYTES)) ? r_count + t_count'(1)
                                                          : t_count'(MAX_PACKET_BYTES);
        recv      = {r_delay[7:0], i_data};
        too_short = n_count < t_count'(3);
        match     = (n_crc == recv);
        plen_full = n_count - t_count'(2);
    end

    always_comb begin
        o_result.packets_total = r_packets + TOTAL_W'(1);
        if (too_short) begin
            o_result.verdict        = VERDICT_TOO_SHORT;
            o_result.calc_crc       = '0;
            o_result.trailer_crc    = '0;
            o_result.payload_length = '0;
            o_result.error_total    = r_errors + TOTAL_W'(1);
            o_result.ok_total       = r_oks;
        end else begin
            o_result.verdict        = match ? VERDICT_OK : VERDICT_MISMATCH;
            o_result.calc_crc       = n_crc;
            o_result.trailer_crc    = recv;
            o_result.payload_length = plen_full[LENGTH_W-1:0];
            o_result.error_total    = match ? r_errors : r_errors + TOTAL_W'(1);
            o_result.ok_total       = match ? r_oks + TOTAL_W'(1) : r_oks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_delay   <= '0;
            r_count   <= '0;
            r_packets <= '0;
            r_errors  <= '0;
            r_oks     <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_crc     <= CRC_INIT;
                r_delay   <= '0;
                r_count   <= '0;
                r_packets <= o_result.packets_total;
                r_errors  <= o_result.error_total;
                r_oks     <= o_result.ok_total;
            end else begin
                r_crc   <= n_crc;
                r_delay <= recv;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/packet_crc16_checker.sv -----
// Packet CRC-16 checker: one byte per cycle in, one result per packet out.
// A final byte passes from the input register into the result register, where
// its result is held until it is taken.
// Throughput: one byte every cycle; a final byte stalls only while the
// result register still holds an untaken result.
// Reset (synchronous, active low) empties both registers, sets the running
// CRC to 0xFFFF and clears the byte count and all three counters.
`default_nettype none

module packet_crc16_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pcrc_byte_if.sink     i_byte,
    pcrc_result_if.source o_result
);
    import pcrc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       out_free;
    logic       advance;

    // Only a final byte needs room in the result register.
    assign out_free     = !r_out_valid || o_result.ready;
    assign advance      = r_in_valid && (!r_in_last || out_free);
    assign i_byte.ready = !r_in_valid || advance;

    pcrc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_data   (r_in_data),
        .i_last   (r_in_last),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_data <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.verdict        = r_out.verdict;
    assign o_result.calc_crc       = r_out.calc_crc;
    assign o_result.trailer_crc    = r_out.trailer_crc;
    assign o_result.payload_length = r_out.payload_length;
    assign o_result.packets_total  = r_out.packets_total;
    assign o_result.error_total    = r_out.error_total;
    assign o_result.ok_total       = r_out.ok_total;

endmodule

`default_nettype wire
